/* src/pwsd_pkg.sv */
// shared types and constants for the pairwise squared distance block
// no dependencies
`timescale 1ns / 1ps

package pwsd_pkg;

    localparam int unsigned FEAT_W  = 16;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned DIST_W  = 36;
    localparam int unsigned SQ_W    = 34;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic              valid;
        logic              add;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
        logic              ovf;
        logic [DIST_W-1:0] sum;
    } t_tok;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DIST_W-1:0] distance;
        logic              last;
        logic              ovf;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

endpackage

/* src/pairwise_squared_distance_matrix.sv */
// top level: row intake, read sequencer, chain of FEATURES_MAX cells, result queue
// flow: new distances enter the chain while earlier ones are still in it, limited by
// four queue credits; rows taken one at a time, input stalls from a row's last element
// until its results have left the chain
// reset: synchronous active low, clears counters and control; the row store is not cleared
// uses pwsd_pkg, pwsd_ram, pwsd_cell, pwsd_fifo
`timescale 1ns / 1ps

module pairwise_squared_distance_matrix #(
    parameter int unsigned ROWS_MAX     = 64,
    parameter int unsigned FEATURES_MAX = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [pwsd_pkg::FEAT_W-1:0] i_feature_value,
    input  logic                          i_new_set,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pwsd_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pwsd_pkg::IDX_W-1:0]    o_row_index,
    output logic [pwsd_pkg::IDX_W-1:0]    o_col_index,
    output logic [pwsd_pkg::DIST_W-1:0]   o_distance,
    output logic                          o_last,
    output logic                          o_overflow
);
    import pwsd_pkg::*;

    localparam int unsigned DEPTH   = ROWS_MAX * FEATURES_MAX;
    localparam int unsigned AW      = $clog2(DEPTH);
    localparam int unsigned RW      = $clog2(ROWS_MAX + 1);
    localparam int unsigned CW      = $clog2(FEATURES_MAX + 1);
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QW      = $clog2(QDEPTH + 1);
    localparam int unsigned LW      = AW + RW + CW;

    t_state            r_state;
    logic [CFG_W-1:0]  r_fc;
    logic [RW-1:0]     r_row_cnt;
    logic [CW-1:0]     r_ec;
    logic [RW-1:0]     r_cur_row;
    logic              r_ovf;
    logic [RW-1:0]     r_col;
    logic [RW-1:0]     r_cur_col;
    logic [CW-1:0]     r_k;
    logic [QW-1:0]     r_inflight;
    t_tok              r_inj;

    logic [CW-1:0]     cnt;
    logic              in_acc;
    logic [RW-1:0]     rc;
    logic [CW-1:0]     ec0;
    logic [CW:0]       ec1;
    logic              row_done;
    logic              store_ok;
    logic [LW-1:0]     waddr_w;
    logic [LW-1:0]     raddr_w;
    logic [RW-1:0]     rd_row;
    logic              issue;
    logic              tok_last;
    logic [QW:0]       credit;
    logic [FEAT_W-1:0] stored;
    t_tok              chain [FEATURES_MAX+1];
    t_res              q_in;
    t_res              q_out;
    logic [QW-1:0]     q_count;
    logic              q_pop;

    always_comb begin
        if (r_fc == '0) begin
            cnt = CW'(1);
        end else if ({{(LW-CFG_W){1'b0}}, r_fc} > LW'(FEATURES_MAX)) begin
            cnt = CW'(FEATURES_MAX);
        end else begin
            cnt = CW'(r_fc);
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;

    always_comb begin
        rc       = i_new_set ? '0 : r_row_cnt;
        ec0      = i_new_set ? '0 : r_ec;
        if (ec0 >= cnt) begin
            ec0 = '0;
        end
        ec1      = {1'b0, ec0} + 1'b1;
        row_done = (ec1 >= {1'b0, cnt});
        store_ok = (rc < RW'(ROWS_MAX));
        waddr_w  = LW'(rc) * LW'(FEATURES_MAX) + LW'(ec0);
        rd_row   = (r_k == '0) ? r_col : r_cur_col;
        raddr_w  = LW'(rd_row) * LW'(FEATURES_MAX) + LW'(r_k);
        credit   = {1'b0, q_count} + {1'b0, r_inflight};
        issue    = (r_state == S_RUN) && (r_k == '0) && (credit < (QW+1)'(QDEPTH));
        tok_last = r_ovf || (r_col == r_cur_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fc       <= CFG_W'(1);
            r_row_cnt  <= '0;
            r_ec       <= '0;
            r_k        <= '0;
            r_inflight <= '0;
            r_inj.valid <= 1'b0;
        end else begin
            r_inj.valid <= issue;
            r_inflight  <= r_inflight + QW'(issue) - QW'(chain[FEATURES_MAX].valid);
            if (issue) begin
                r_k <= (cnt == CW'(1)) ? '0 : CW'(1);
            end else if (r_k != '0) begin
                r_k <= (r_k == cnt - 1'b1) ? '0 : r_k + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (row_done) begin
                            r_ec      <= '0;
                            r_row_cnt <= store_ok ? rc + 1'b1 : rc;
                            r_state   <= S_RUN;
                        end else begin
                            r_ec      <= ec1[CW-1:0];
                            r_row_cnt <= rc;
                        end
                    end
                end
                S_RUN: begin
                    if (issue && tok_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_inflight == '0) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_valid) begin
                r_fc <= i_cfg_data;
                r_ec <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && row_done) begin
            r_cur_row <= rc;
            r_ovf     <= !store_ok;
            r_col     <= '0;
        end else if (issue) begin
            r_col     <= r_col + 1'b1;
        end
        if (issue) begin
            r_cur_col  <= r_col;
            r_inj.add  <= !tok_last;
            r_inj.row  <= r_ovf ? '0 : IDX_W'(r_cur_row);
            r_inj.col  <= r_ovf ? '0 : IDX_W'(r_col);
            r_inj.last <= tok_last;
            r_inj.ovf  <= r_ovf;
            r_inj.sum  <= '0;
        end
    end

    pwsd_ram #(
        .WIDTH (FEAT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && store_ok),
        .i_waddr (waddr_w[AW-1:0]),
        .i_wdata (i_feature_value),
        .i_raddr (raddr_w[AW-1:0]),
        .o_rdata (stored)
    );

    assign chain[0] = r_inj;

    for (genvar g = 0; g < FEATURES_MAX; g++) begin : g_cell
        pwsd_cell #(
            .IDX   (g),
            .CNT_W (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (in_acc && (ec0 == CW'(g))),
            .i_load_value (i_feature_value),
            .i_cnt        (cnt),
            .i_stored     (stored),
            .i_tok        (chain[g]),
            .o_tok        (chain[g+1])
        );
    end

    always_comb begin
        q_in.row      = chain[FEATURES_MAX].row;
        q_in.col      = chain[FEATURES_MAX].col;
        q_in.distance = chain[FEATURES_MAX].sum;
        q_in.last     = chain[FEATURES_MAX].last;
        q_in.ovf      = chain[FEATURES_MAX].ovf;
    end

    assign q_pop = o_valid && i_ready;

    pwsd_fifo #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (chain[FEATURES_MAX].valid),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_count (q_count)
    );

    assign o_valid     = (q_count != '0);
    assign o_row_index = q_out.row;
    assign o_col_index = q_out.col;
    assign o_distance  = q_out.distance;
    assign o_last      = q_out.last;
    assign o_overflow  = q_out.ovf;

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, q_count} + {1'b0, r_inflight}) <= (QW+1)'(QDEPTH))
        else $error("result queue over committed");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_inflight == '0))
        else $error("request taken while chain busy");

    a_ovf_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_last && o_row_index == '0 && o_col_index == '0
            && o_distance == '0))
        else $error("malformed overflow result");

    a_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && !o_overflow) |-> (o_row_index == o_col_index
            && o_distance == '0))
        else $error("malformed diagonal result");

endmodule

/* src/pwsd_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pwsd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/pwsd_cell.sv */
// one cell of the distance chain: holds one element of the new row and adds
// its squared difference against the broadcast stored element; uses pwsd_pkg
`timescale 1ns / 1ps

module pwsd_cell #(
    parameter int unsigned IDX    = 0,
    parameter int unsigned CNT_W  = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [pwsd_pkg::FEAT_W-1:0] i_load_value,
    input  logic [CNT_W-1:0]           i_cnt,
    input  logic [pwsd_pkg::FEAT_W-1:0] i_stored,
    input  pwsd_pkg::t_tok             i_tok,
    output pwsd_pkg::t_tok             o_tok
);
    import pwsd_pkg::*;

    logic [FEAT_W-1:0]       r_x;
    t_tok                    r_tok;
    t_tok                    n_tok;
    logic signed [FEAT_W:0]  diff;
    logic signed [SQ_W-1:0]  prod;
    logic [DIST_W:0]         acc;
    logic                    active;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_load_value;
        end
    end

    always_comb begin
        diff   = $signed({r_x[FEAT_W-1], r_x}) - $signed({i_stored[FEAT_W-1], i_stored});
        prod   = diff * diff;
        acc    = {1'b0, i_tok.sum} + {{(DIST_W + 1 - SQ_W){1'b0}}, prod};
        active = i_tok.add && (CNT_W'(IDX) < i_cnt);
        n_tok  = i_tok;
        if (active) begin
            n_tok.sum = acc[DIST_W] ? DIST_MAX : acc[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.add  <= n_tok.add;
        r_tok.row  <= n_tok.row;
        r_tok.col  <= n_tok.col;
        r_tok.last <= n_tok.last;
        r_tok.ovf  <= n_tok.ovf;
        r_tok.sum  <= n_tok.sum;
    end

    assign o_tok = r_tok;

endmodule

/* src/pwsd_fifo.sv */
// small result queue between the cell chain and the output port
// uses pwsd_pkg
`timescale 1ns / 1ps

module pwsd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  pwsd_pkg::t_res             i_data,
    input  logic                       i_pop,
    output pwsd_pkg::t_res             o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import pwsd_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_res          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

/* test/pwsd_checker.sv */
// checker for the pairwise squared distance block: predicts results from accepted requests
// and compares them with the accepted outputs; depends on pwsd_pkg
`timescale 1ns / 1ps

module pwsd_checker #(
    parameter int unsigned ROWS_MAX     = 64,
    parameter int unsigned FEATURES_MAX = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               o_ready,
    input  logic signed [pwsd_pkg::FEAT_W-1:0] i_feature_value,
    input  logic                               i_new_set,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic [pwsd_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               o_valid,
    input  logic                               i_ready,
    input  logic [pwsd_pkg::IDX_W-1:0]         o_row_index,
    input  logic [pwsd_pkg::IDX_W-1:0]         o_col_index,
    input  logic [pwsd_pkg::DIST_W-1:0]        o_distance,
    input  logic                               o_last,
    input  logic                               o_overflow,
    output int                                 fail_count,
    output int                                 pending
);
    import pwsd_pkg::*;

    logic signed [FEAT_W-1:0] feat_mem [ROWS_MAX][FEATURES_MAX];
    logic [6:0]               row_cnt;
    logic [4:0]               elem_cnt;
    logic [CFG_W-1:0]         count_reg;
    t_res                     dist_queue [$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            fail_count++;
        end
    endtask

    function automatic logic [DIST_W-1:0] row_distance(input int a, input int b, input int cnt);
        longint sum;
        longint d;
        begin
            sum = 0;
            for (int k = 0; k < cnt; k++) begin
                d = longint'(feat_mem[a][k]) - longint'(feat_mem[b][k]);
                sum += d * d;
                if (sum > longint'(DIST_MAX)) sum = longint'(DIST_MAX);
            end
            return sum[DIST_W-1:0];
        end
    endfunction

    task automatic predict_element(input logic signed [FEAT_W-1:0] v, input logic ns);
        int   cnt;
        t_res r;
        begin
            cnt = (count_reg == 0) ? 1 : (count_reg > FEATURES_MAX) ? FEATURES_MAX : count_reg;
            if (ns) begin
                row_cnt  = 0;
                elem_cnt = 0;
            end
            if (elem_cnt >= cnt) elem_cnt = 0;
            if (row_cnt < ROWS_MAX) feat_mem[row_cnt][elem_cnt] = v;
            elem_cnt++;
            if (elem_cnt >= cnt) begin
                elem_cnt = 0;
                if (row_cnt >= ROWS_MAX) begin
                    r = '{row: 0, col: 0, distance: 0, last: 1'b1, ovf: 1'b1};
                    dist_queue.push_back(r);
                end else begin
                    for (int j = 0; j < row_cnt; j++) begin
                        r = '{row: row_cnt[IDX_W-1:0], col: j[IDX_W-1:0],
                              distance: row_distance(row_cnt, j, cnt), last: 1'b0,
                              ovf: 1'b0};
                        dist_queue.push_back(r);
                    end
                    r = '{row: row_cnt[IDX_W-1:0], col: row_cnt[IDX_W-1:0],
                          distance: 0, last: 1'b1, ovf: 1'b0};
                    dist_queue.push_back(r);
                    row_cnt++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_res w;
        if (!i_rst_n) begin
            row_cnt    = 0;
            elem_cnt   = 0;
            count_reg  = 1;
            fail_count = 0;
            dist_queue.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                count_reg = i_cfg_data;
                elem_cnt  = 0;
            end
            if (i_valid && o_ready) predict_element(i_feature_value, i_new_set);
            if (o_valid && i_ready) begin
                if (dist_queue.size() == 0) begin
                    report_mismatch("unexpected result, row", o_row_index, 0);
                end else begin
                    w = dist_queue.pop_front();
                    if (o_row_index !== w.row) report_mismatch("row_index", o_row_index, w.row);
                    if (o_col_index !== w.col) report_mismatch("col_index", o_col_index, w.col);
                    if (o_distance !== w.distance) begin
                        report_mismatch("distance", o_distance, w.distance);
                    end
                    if (o_last !== w.last) report_mismatch("last", o_last, w.last);
                    if (o_overflow !== w.ovf) report_mismatch("overflow", o_overflow, w.ovf);
                end
            end
        end
        pending = dist_queue.size();
    end

endmodule

/* test/testbench.sv */
// stimulus and verdict for the pairwise squared distance block
// depends on pwsd_pkg, pairwise_squared_distance_matrix and pwsd_checker
`timescale 1ns / 1ps

module testbench;
    import pwsd_pkg::*;

    localparam int RUN_LIMIT = 400000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic signed [FEAT_W-1:0] i_feature_value;
    logic                     i_new_set;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     o_valid;
    logic                     i_ready;
    logic [IDX_W-1:0]         o_row_index;
    logic [IDX_W-1:0]         o_col_index;
    logic [DIST_W-1:0]        o_distance;
    logic                     o_last;
    logic                     o_overflow;
    int                       fail_count;
    int                       pending;
    int                       cycles;
    bit                       idle_on;
    bit                       hold_req;
    bit                       rst_done;

    pairwise_squared_distance_matrix uut (.*);

    pwsd_checker chk (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [FEAT_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return FEAT_W'($urandom_range(0, 15)) - 16'sd8;
            default: return FEAT_W'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic signed [FEAT_W-1:0] v, input logic ns);
        int g;
        begin
            g = idle_on ? $urandom_range(0, 5) : 0;
            if (g > 0) begin
                i_valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_valid         <= 1'b1;
            i_feature_value <= v;
            i_new_set       <= ns;
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
        end
    endtask

    task automatic write_count(input logic [CFG_W-1:0] c);
        begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0) @(posedge i_clk);
            repeat (30) @(posedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= c;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            i_cfg_valid <= 1'b0;
        end
    endtask

    // receiver side
    initial begin
        int g;
        i_ready = 1'b0;
        wait (rst_done);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                g = idle_on ? $urandom_range(0, 5) : 0;
                if (g > 0) begin
                    i_ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        logic [CFG_W-1:0]         cfg_list [6];
        int                       len_list [6];
        logic signed [FEAT_W-1:0] corner [8];
        logic signed [FEAT_W-1:0] v;
        logic                     ns;
        cfg_list = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd2};
        len_list = '{70, 48, 32, 48, 20, 12};
        corner   = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1,
                     16'sh8000, 16'sh7fff, 16'sh5555};
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_feature_value = '0;
        i_new_set       = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        idle_on         = 1'b1;
        hold_req        = 1'b0;
        rst_done        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 6; p++) begin
            write_count(cfg_list[p]);
            idle_on = (p != 2);
            for (int i = 0; i < len_list[p]; i++) begin
                // the first set runs past capacity, so no restarts there
                ns = (i == 0) || (p != 0 && $urandom_range(0, 15) == 0);
                if (p == 0 && i < 8) v = corner[i];
                else if (p == 3 && i < 32) v = (i < 16) ? 16'sh8000 : 16'sh7fff;
                else v = pick_value();
                if (p == 0 && i == 30) hold_req = 1'b1;
                if (p == 1 && i == 24) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                send_request(v, ns);
            end
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/pwsd_pkg.sv
src/pwsd_ram.sv
src/pwsd_cell.sv
src/pwsd_fifo.sv
src/pairwise_squared_distance_matrix.sv
test/pwsd_checker.sv
test/testbench.sv
